// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on i_clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/trdb_pkg.sv =====
// ----------------------------------------------------------------------------
// trdb_pkg
// Types and constants shared by the tape record deblocker modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package trdb_pkg;

    localparam int unsigned C_MAX_BLOCK = 65535;
    localparam int unsigned C_Q_DEPTH   = 4;
    localparam int unsigned C_Q_AW      = $clog2(C_Q_DEPTH);
    localparam int unsigned C_Q_CW      = $clog2(C_Q_DEPTH + 1);

    localparam logic [1:0] FMT_UNDEF = 2'd0;
    localparam logic [1:0] FMT_FIXED = 2'd1;
    localparam logic [1:0] FMT_VAR   = 2'd2;

    localparam logic REG_FORMAT = 1'b0;
    localparam logic REG_LENGTH = 1'b1;

    typedef enum logic [3:0] {
        PH_START   = 4'b0001,
        PH_DESC_LO = 4'b0010,
        PH_DATA    = 4'b0100,
        PH_SKIP    = 4'b1000
    } t_phase;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       record_end;
        logic       bad_block;
    } t_result;

    typedef struct packed {
        logic    valid;
        t_result data;
    } t_push;

endpackage

`default_nettype wire

// ===== rtl/trdb_front.sv =====
// ----------------------------------------------------------------------------
// trdb_front
// Accepts block bytes, tracks block and record position, classifies each
// beat and pushes at most one result into the queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module trdb_front (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic             i_cfg_idx,
    input  wire logic [15:0]      i_cfg_data,
    input  wire logic             i_valid,
    input  wire logic [7:0]       i_data_byte,
    input  wire logic [15:0]      i_block_length,
    input  wire logic             i_full,
    output trdb_pkg::t_push       o_push
);
    import trdb_pkg::*;

    logic [1:0]  r_format;
    logic [15:0] r_rec_len;
    logic [15:0] r_pos, n_pos;
    logic [15:0] r_rem, n_rem;
    logic [7:0]  r_dh, n_dh;
    t_phase      r_phase, n_phase;
    logic        r_halted, n_halted;

    logic        w_accept;
    logic [15:0] w_len;
    logic [16:0] w_pos_inc;
    logic        w_last;
    logic        w_err;
    logic [15:0] w_rem_base;
    logic [15:0] w_rlen;
    logic [16:0] w_span;
    logic [7:0]  w_dh_dec;
    t_push       w_push;

    assign w_accept  = i_valid && !i_full;
    assign w_len     = (32'(i_block_length) > C_MAX_BLOCK) ? 16'(C_MAX_BLOCK)
                                                           : i_block_length;
    assign w_pos_inc = {1'b0, r_pos} + 17'd1;
    assign w_last    = w_pos_inc >= {1'b0, w_len};
    assign w_rem_base = (r_phase != PH_DATA) ? r_rec_len : r_rem;
    assign w_rlen    = {r_dh, i_data_byte};
    assign w_span    = {1'b0, r_pos} - 17'd1 + {1'b0, w_rlen};
    assign w_dh_dec  = r_dh - 8'd1;

    always_comb begin
        n_pos    = r_pos;
        n_rem    = r_rem;
        n_dh     = r_dh;
        n_phase  = r_phase;
        n_halted = r_halted;
        w_err    = 1'b0;
        w_push   = '0;
        if (w_accept && !r_halted) begin
            case (r_format)
                FMT_FIXED: begin
                    n_rem = w_rem_base - 16'd1;
                    w_push.valid           = 1'b1;
                    w_push.data.out_byte   = i_data_byte;
                    w_push.data.byte_valid = 1'b1;
                    if ((n_rem == 16'd0) || w_last) begin
                        w_push.data.record_end = 1'b1;
                        n_phase = PH_START;
                    end else begin
                        n_phase = PH_DATA;
                    end
                end
                FMT_VAR: begin
                    if (r_pos == 16'd0) begin
                        w_err   = (w_len < 16'd8);
                        n_phase = PH_START;
                    end else if (r_pos < 16'd4) begin
                        n_phase = PH_START;
                    end else begin
                        unique case (r_phase)
                            PH_START: begin
                                if (({1'b0, r_pos} + 17'd4) > {1'b0, w_len}) begin
                                    w_err = 1'b1;
                                end else begin
                                    n_dh    = i_data_byte;
                                    n_phase = PH_DESC_LO;
                                end
                            end
                            PH_DESC_LO: begin
                                if ((w_rlen < 16'd4) || (w_span > {1'b0, w_len})) begin
                                    w_err = 1'b1;
                                end else begin
                                    n_rem   = w_rlen - 16'd4;
                                    n_dh    = 8'd2;
                                    n_phase = PH_SKIP;
                                end
                            end
                            PH_SKIP: begin
                                n_dh = w_dh_dec;
                                if (w_dh_dec == 8'd0) begin
                                    if (r_rem == 16'd0) begin
                                        w_push.valid           = 1'b1;
                                        w_push.data.record_end = 1'b1;
                                        n_phase = PH_START;
                                    end else begin
                                        n_phase = PH_DATA;
                                    end
                                end
                            end
                            PH_DATA: begin
                                n_rem = r_rem - 16'd1;
                                w_push.valid           = 1'b1;
                                w_push.data.out_byte   = i_data_byte;
                                w_push.data.byte_valid = 1'b1;
                                if ((n_rem == 16'd0) || w_last) begin
                                    w_push.data.record_end = 1'b1;
                                    n_phase = PH_START;
                                end
                            end
                            default: n_phase = PH_START;
                        endcase
                    end
                end
                default: begin
                    w_push.valid           = 1'b1;
                    w_push.data.out_byte   = i_data_byte;
                    w_push.data.byte_valid = 1'b1;
                    w_push.data.record_end = w_last;
                    n_phase = PH_START;
                end
            endcase
            if (w_err) begin
                // report once, then halt
                w_push        = '0;
                w_push.valid  = 1'b1;
                w_push.data.bad_block = 1'b1;
                n_halted      = 1'b1;
                n_pos         = r_pos;
                n_phase       = r_phase;
            end else if (w_last) begin
                n_pos   = 16'd0;
                n_phase = PH_START;
            end else begin
                n_pos = w_pos_inc[15:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_format  <= FMT_UNDEF;
            r_rec_len <= 16'd80;
            r_pos     <= '0;
            r_rem     <= '0;
            r_dh      <= '0;
            r_phase   <= PH_START;
            r_halted  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_FORMAT: r_format  <= i_cfg_data[1:0];
                    REG_LENGTH: r_rec_len <= i_cfg_data;
                    default: ;
                endcase
            end
            r_pos    <= n_pos;
            r_rem    <= n_rem;
            r_dh     <= n_dh;
            r_phase  <= n_phase;
            r_halted <= n_halted;
        end
    end

    assign o_push = w_push;

endmodule

`default_nettype wire

// ===== rtl/trdb_queue.sv =====
// ----------------------------------------------------------------------------
// trdb_queue
// Short result queue; its head drives the output channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module trdb_queue (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire trdb_pkg::t_push  i_push,
    output logic                  o_full,
    output logic                  o_valid,
    input  wire logic             i_stall,
    output trdb_pkg::t_result     o_head
);
    import trdb_pkg::*;

    t_result                 r_mem [C_Q_DEPTH];
    logic [C_Q_AW-1:0]       r_wr_ptr;
    logic [C_Q_AW-1:0]       r_rd_ptr;
    logic [C_Q_CW-1:0]       r_count, n_count;
    logic                    w_pop;

    assign o_full  = (r_count == C_Q_CW'(C_Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign w_pop   = o_valid && !i_stall;

    always_comb begin
        n_count = r_count;
        if (i_push.valid && !w_pop) begin
            n_count = r_count + C_Q_CW'(1);
        end else if (!i_push.valid && w_pop) begin
            n_count = r_count - C_Q_CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[r_wr_ptr] <= i_push.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push.valid) begin
                r_wr_ptr <= r_wr_ptr + C_Q_AW'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + C_Q_AW'(1);
            end
            r_count <= n_count;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/tape_record_deblocker.sv =====
// ----------------------------------------------------------------------------
// tape_record_deblocker
// Splits tape blocks into logical records (undefined, fixed, variable).
// ----------------------------------------------------------------------------
// Takes one block byte per cycle and gives at most one result beat per byte.
// The front end decides each beat in the cycle it is accepted and writes the
// result into a four-entry queue to be offered from its head; the input
// stalls only while that queue is full. A corrupt block gives a single beat
// with bad_block set, after which bytes are taken and dropped until reset.
// Configuration is written through i_cfg_we/i_cfg_idx/i_cfg_data.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module tape_record_deblocker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_idx,
    input  wire logic [15:0] i_cfg_data,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic [15:0] i_block_length,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [7:0]       o_out_byte,
    output logic             o_byte_valid,
    output logic             o_record_end,
    output logic             o_bad_block
);
    import trdb_pkg::*;

    t_push   w_push;
    t_result w_head;
    logic    w_full;

    trdb_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .i_data_byte    (i_data_byte),
        .i_block_length (i_block_length),
        .i_full         (w_full),
        .o_push         (w_push)
    );

    trdb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .o_full  (w_full),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_head  (w_head)
    );

    assign o_stall      = w_full;
    assign o_out_byte   = w_head.out_byte;
    assign o_byte_valid = w_head.byte_valid;
    assign o_record_end = w_head.record_end;
    assign o_bad_block  = w_head.bad_block;

    `ASSERT_SAME(a_no_push_full, w_push.valid, !w_full, "push into full queue")
    `ASSERT_NEXT(a_halt_after_bad, w_push.valid && w_push.data.bad_block, !w_push.valid,
                 "result after bad block")
    `ASSERT_SAME(a_empty_rec_end, w_push.valid && !w_push.data.byte_valid
                 && !w_push.data.bad_block, w_push.data.record_end,
                 "dataless beat without record end")

endmodule

`default_nettype wire
